>>> hw/rtl/art_pkg.sv
// ----------------------------------------------------------------------------
// address registry table package
// shared codes, widths, state machine type and control/status structs
// ----------------------------------------------------------------------------
package art_pkg;

   // default number of table slots
   localparam int DEF_TABLE_DEPTH = 32;

   // fixed field widths
   localparam int ACTION_W = 2;
   localparam int ADDR_W   = 32;
   localparam int KIND_W   = 2;
   localparam int SLOT_W   = 5;
   localparam int COUNT_W  = 6;

   // request actions
   localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_LIST   = 2'd2;

   // response kinds
   localparam logic [KIND_W-1:0] KIND_ADD_REPLY  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LIST_HEAD  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LIST_ENTRY = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH,
      ST_HEAD,
      ST_SELECT,
      ST_EMIT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic latch;       // capture request transaction
      logic scan_clr;    // rewind slot index, clear search results
      logic scan_rd;     // read slot at index for compare, advance index
      logic list_rd;     // read slot at index for list output
      logic idx_inc;     // advance slot index
      logic commit_add;  // store address in first empty slot if absent
      logic commit_rm;   // free the matching slot
      logic out_add;     // load add reply into output register
      logic out_head;    // load list header into output register
      logic out_entry;   // load list entry into output register
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic idx_last;    // index sits on the last slot
      logic occ_at_idx;  // slot at index is occupied
      logic out_free;    // output register can take a new transaction
      logic entry_last;  // next list entry is the final one
      logic count_zero;  // table is empty
      logic is_add;      // latched action is add
   } stat_type;

endpackage

>>> hw/rtl/art_req_if.sv
// ----------------------------------------------------------------------------
// address registry request channel
// valid/ready channel carrying action and address
// ----------------------------------------------------------------------------
interface art_req_if
   import art_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [ADDR_W-1:0]   address;

   modport source (output valid, output action, output address, input ready);
   modport sink   (input valid, input action, input address, output ready);
endinterface

>>> hw/rtl/art_rsp_if.sv
// ----------------------------------------------------------------------------
// address registry response channel
// valid/ready channel carrying add replies and list results
// ----------------------------------------------------------------------------
interface art_rsp_if
   import art_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [SLOT_W-1:0]  slot;
   logic               table_full;
   logic [COUNT_W-1:0] entry_count;
   logic [ADDR_W-1:0]  entry_value;
   logic               last;

   modport source (output valid, output kind, output slot, output table_full,
                   output entry_count, output entry_value, output last,
                   input ready);
   modport sink   (input valid, input kind, input slot, input table_full,
                   input entry_count, input entry_value, input last,
                   output ready);
endinterface

>>> hw/rtl/address_registry_table.sv
// ----------------------------------------------------------------------------
// address registry table
// table of client addresses with add, remove and list commands
// ----------------------------------------------------------------------------
//
// channel    dir  transaction contents
// ---------  ---  --------------------------------------------------------
// req_chan   in   action (add, remove, list) and 32-bit address
// rsp_chan   out  kind, slot, table_full, entry_count, entry_value, last
//
// add and remove scan every slot through the single ram read port: accept,
// a read of every slot, one compare drain, then one commit (an add waits for
// a free output register); remove gives no response transaction
// list: the head state loads the header after accept; then empty slots are
// skipped and occupied ones read and emitted, up to the last occupied one
// reset clears the occupancy bits and slot count, no clearing pass
// a stalled response holds in the output register; the next request is taken
// while it waits, and the sequencer only pauses when it must load a new one
//
module address_registry_table
   import art_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   art_req_if.sink   req_chan,
   art_rsp_if.source rsp_chan
);
   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   // controller: one request at a time
   art_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // datapath: slot ram, occupancy, search and response register
   art_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_action      (req_chan.action),
      .req_address     (req_chan.address),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_kind        (rsp_chan.kind),
      .rsp_slot        (rsp_chan.slot),
      .rsp_table_full  (rsp_chan.table_full),
      .rsp_entry_count (rsp_chan.entry_count),
      .rsp_entry_value (rsp_chan.entry_value),
      .rsp_last        (rsp_chan.last)
   );

   assign req_chan.ready = req_ready;

`ifndef SYNTHESIS
   // a response is only loaded when the output register can take it
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_add || cmd.out_head || cmd.out_entry) |-> stat.out_free)
      else $error("response loaded over a pending transaction");

   // one response source at a time
   a_load_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.out_add, cmd.out_head, cmd.out_entry}))
      else $error("more than one response source");

   // list reads only fetch occupied slots
   a_list_occ: assert property (@(posedge clock) disable iff (reset)
      cmd.list_rd |-> stat.occ_at_idx)
      else $error("list read of an empty slot");

   // after a list entry flagged last, the block returns to accepting requests
   a_list_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_entry && stat.entry_last) |=> req_ready)
      else $error("controller did not return to idle after final entry");
`endif
endmodule

>>> hw/rtl/art_ram.sv
// ----------------------------------------------------------------------------
// generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module art_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/art_ctrl.sv
// ----------------------------------------------------------------------------
// address registry controller
// sequences scans, commits and result emission
// ----------------------------------------------------------------------------
module art_ctrl
   import art_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [ACTION_W-1:0] req_action,
   output logic                req_ready,
   input  stat_type            stat,
   output cmd_type             cmd
);
   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch    = 1'b1;
               cmd.scan_clr = 1'b1;
               if (req_action inside {ACT_ADD, ACT_REMOVE}) begin
                  state_in = ST_SCAN;
               end else if (req_action == ACT_LIST) begin
                  state_in = ST_HEAD;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (stat.idx_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.is_add) begin
               if (stat.out_free) begin
                  cmd.out_add    = 1'b1;
                  cmd.commit_add = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else begin
               cmd.commit_rm = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_HEAD: begin
            if (stat.out_free) begin
               cmd.out_head = 1'b1;
               cmd.scan_clr = 1'b1;
               state_in     = stat.count_zero ? ST_IDLE : ST_SELECT;
            end
         end
         ST_SELECT: begin
            if (stat.occ_at_idx) begin
               cmd.list_rd = 1'b1;
               state_in    = ST_EMIT;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.out_entry = 1'b1;
               cmd.idx_inc   = 1'b1;
               state_in      = stat.entry_last ? ST_IDLE : ST_SELECT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

>>> hw/rtl/art_dp.sv
// ----------------------------------------------------------------------------
// address registry datapath
// slot store, occupancy bits, scan compare, counters and output register
// ----------------------------------------------------------------------------
module art_dp
   import art_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [ADDR_W-1:0]   req_address,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic                rsp_table_full,
   output logic [COUNT_W-1:0]  rsp_entry_count,
   output logic [ADDR_W-1:0]   rsp_entry_value,
   output logic                rsp_last
);
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // latched request
   logic [ACTION_W-1:0] action_ff;
   logic [ADDR_W-1:0]   addr_ff;

   // slot index and compare stage
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             cmp_vld_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic             cmp_occ_ff;

   // search results
   logic             hit_found_ff, hit_found_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             empty_found_ff, empty_found_in;
   logic [IDX_W-1:0] empty_idx_ff, empty_idx_in;

   // occupancy and counters
   logic [TABLE_DEPTH-1:0] occ_ff, occ_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       emitted_ff, emitted_in;
   logic [CNT_W-1:0]       emitted_nx;

   // output register
   logic               out_vld_ff, out_vld_in;
   logic [KIND_W-1:0]  out_kind_ff;
   logic [SLOT_W-1:0]  out_slot_ff;
   logic               out_full_ff;
   logic [COUNT_W-1:0] out_count_ff;
   logic [ADDR_W-1:0]  out_value_ff;
   logic               out_last_ff;

   logic [ADDR_W-1:0] ram_q;
   logic              ram_wr;
   logic              match;
   logic              out_free;
   logic              do_add;
   logic              do_rm;

   art_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (TABLE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (empty_idx_ff),
      .wr_data (addr_ff),
      .rd_en   (cmd.scan_rd | cmd.list_rd),
      .rd_addr (idx_ff),
      .rd_data (ram_q)
   );

   // empty slot reads as zero
   assign match    = cmp_occ_ff ? (ram_q == addr_ff) : (addr_ff == '0);
   assign out_free = !out_vld_ff || rsp_ready;
   assign do_add   = cmd.commit_add && !hit_found_ff && empty_found_ff;
   assign do_rm    = cmd.commit_rm && hit_found_ff && (addr_ff != '0);
   assign ram_wr   = do_add;
   assign emitted_nx = emitted_ff + CNT_W'(1);

   always_comb begin
      idx_in = idx_ff;
      if (cmd.scan_clr) begin
         idx_in = '0;
      end else if (cmd.scan_rd || cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      hit_found_in   = hit_found_ff;
      hit_idx_in     = hit_idx_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      if (cmd.scan_clr) begin
         hit_found_in   = 1'b0;
         empty_found_in = 1'b0;
      end else if (cmp_vld_ff) begin
         if (match && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = cmp_idx_ff;
         end
         if (!cmp_occ_ff && !empty_found_ff) begin
            empty_found_in = 1'b1;
            empty_idx_in   = cmp_idx_ff;
         end
      end
   end

   always_comb begin
      occ_in   = occ_ff;
      count_in = count_ff;
      if (do_add) begin
         occ_in[empty_idx_ff] = 1'b1;
         count_in             = count_ff + CNT_W'(1);
      end else if (do_rm) begin
         occ_in[hit_idx_ff] = 1'b0;
         count_in           = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      emitted_in = emitted_ff;
      if (cmd.scan_clr) begin
         emitted_in = '0;
      end else if (cmd.out_entry) begin
         emitted_in = emitted_nx;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff && !rsp_ready;
      if (cmd.out_add || cmd.out_head || cmd.out_entry) begin
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff         <= '0;
         count_ff       <= '0;
         out_vld_ff     <= 1'b0;
         cmp_vld_ff     <= 1'b0;
         idx_ff         <= '0;
         emitted_ff     <= '0;
         hit_found_ff   <= 1'b0;
         empty_found_ff <= 1'b0;
      end else begin
         occ_ff         <= occ_in;
         count_ff       <= count_in;
         out_vld_ff     <= out_vld_in;
         cmp_vld_ff     <= cmd.scan_rd;
         idx_ff         <= idx_in;
         emitted_ff     <= emitted_in;
         hit_found_ff   <= hit_found_in;
         empty_found_ff <= empty_found_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff   <= hit_idx_in;
      empty_idx_ff <= empty_idx_in;
      if (cmd.latch) begin
         action_ff <= req_action;
         addr_ff   <= req_address;
      end
      if (cmd.scan_rd) begin
         cmp_idx_ff <= idx_ff;
         cmp_occ_ff <= occ_ff[idx_ff];
      end
      if (cmd.out_add) begin
         out_kind_ff  <= KIND_ADD_REPLY;
         // full table with no match replies with slot zero
         if (hit_found_ff) begin
            out_slot_ff <= SLOT_W'(hit_idx_ff);
         end else if (empty_found_ff) begin
            out_slot_ff <= SLOT_W'(empty_idx_ff);
         end else begin
            out_slot_ff <= '0;
         end
         out_full_ff  <= !hit_found_ff && !empty_found_ff;
         out_count_ff <= '0;
         out_value_ff <= '0;
         out_last_ff  <= 1'b1;
      end else if (cmd.out_head) begin
         out_kind_ff  <= KIND_LIST_HEAD;
         out_slot_ff  <= '0;
         out_full_ff  <= 1'b0;
         out_count_ff <= COUNT_W'(count_ff);
         out_value_ff <= '0;
         out_last_ff  <= (count_ff == '0);
      end else if (cmd.out_entry) begin
         out_kind_ff  <= KIND_LIST_ENTRY;
         out_slot_ff  <= '0;
         out_full_ff  <= 1'b0;
         out_count_ff <= '0;
         out_value_ff <= ram_q;
         out_last_ff  <= (emitted_nx == count_ff);
      end
   end

   assign stat.idx_last   = (idx_ff == IDX_W'(TABLE_DEPTH - 1));
   assign stat.occ_at_idx = occ_ff[idx_ff];
   assign stat.out_free   = out_free;
   assign stat.entry_last = (emitted_nx == count_ff);
   assign stat.count_zero = (count_ff == '0);
   assign stat.is_add     = (action_ff == ACT_ADD);

   assign rsp_valid       = out_vld_ff;
   assign rsp_kind        = out_kind_ff;
   assign rsp_slot        = out_slot_ff;
   assign rsp_table_full  = out_full_ff;
   assign rsp_entry_count = out_count_ff;
   assign rsp_entry_value = out_value_ff;
   assign rsp_last        = out_last_ff;
endmodule
